// File: sv/fpa_pkg.sv
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  // numerator width of the divider: |a| shifted left by the fraction bits
  localparam int NUM_W = 32 + FRAC_BITS;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_MIN  = 4'd4,
    CMD_MAX  = 4'd5,
    CMD_INC  = 4'd6,
    CMD_DEC  = 4'd7,
    CMD_ITOF = 4'd8,
    CMD_FTOI = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OVF = 2'd1,
    ST_DZ  = 2'd2
  } status_t;

  // one pipeline slot; fields are filled in as the word moves down the stages
  typedef struct packed {
    logic             v;
    logic [3:0]       cmd;
    logic             lt;
    logic             eq;
    logic             gt;
    logic [31:0]      simple;
    status_t          st;
    logic             neg;
    logic             dz;
    logic [31:0]      maga;
    logic [31:0]      den;
    logic [63:0]      prod;
    logic [NUM_W-1:0] num;
    logic [31:0]      rem;
    logic [NUM_W-1:0] quo;
    logic [63:0]      rnd;
  } stage_t;

endpackage

// File: sv/fpa_if.sv
interface fpa_in_if;
  import fpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [3:0]        cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface fpa_out_if;
  import fpa_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [31:0] result;
  logic              a_less;
  logic              a_equal;
  logic              a_greater;
  logic [1:0]        status;

  modport source (output valid, output result, output a_less, output a_equal,
                  output a_greater, output status, input ready);
  modport sink (input valid, input result, input a_less, input a_equal,
                input a_greater, input status, output ready);
endinterface

// File: sv/fixed_point_alu.sv
// Signed Q24.8 ALU: add, sub, mul, div, min, max, inc, dec, int-to-fixed and
// fixed-to-int on two 32-bit raw operands, one result word per input word, with
// compare flags and a status code (overflow saturates, divide by zero is flagged).
// Fully pipelined: a new word is taken every cycle while ready is high, and every
// opcode takes the same path through the pipeline from input accept to output valid;
// the restoring divider, one quotient bit per stage, sets most of its depth. The
// output has a two-entry buffer, so ready upstream is a register: when the output
// stalls, the pipe advances until a word lands in the spare entry and then holds.
module fixed_point_alu (
  input logic       clk,
  input logic       rst_n,
  fpa_in_if.sink    in_ch,
  fpa_out_if.source out_ch
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [31:0] result;
    logic        lt;
    logic        eq;
    logic        gt;
    status_t     st;
  } word_t;

  logic en;

  // input stage
  logic        a_v_r;
  logic [3:0]  a_cmd_r;
  logic [31:0] a_a_r;
  logic [31:0] a_b_r;

  stage_t b_r, b_nxt;
  stage_t c_r, c_nxt;
  stage_t d_out;
  stage_t f1_r, f1_nxt;
  stage_t f2_r, f2_nxt;

  logic  out_v_r, skid_v_r;
  word_t out_r, skid_r, f2_word;

  assign en = !skid_v_r;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
    end
    if (en) begin
      a_cmd_r <= in_ch.cmd;
      a_a_r   <= in_ch.operand_a;
      a_b_r   <= in_ch.operand_b;
    end
  end

  function automatic logic [31:0] sat33(input logic [32:0] s, inout status_t st);
    logic [31:0] r;
    if (s[32] != s[31]) begin
      r  = s[32] ? S32_MIN : S32_MAX;
      st = ST_OVF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // decode, compares, all opcodes other than mul and div, and the divide-by-zero case
  always_comb begin
    logic               sa, sb;
    logic [31:0]        magb;
    logic [32:0]        sum;
    logic [32:0]        dif;
    logic [32:0]        inc;
    logic [32:0]        dec;
    logic [31+FRAC_BITS:0] wide;
    logic [31:0]        ft;

    sa   = a_a_r[31];
    sb   = a_b_r[31];
    magb = sb ? 32'(0 - a_b_r) : a_b_r;
    sum  = {sa, a_a_r} + {sb, a_b_r};
    dif  = {sa, a_a_r} - {sb, a_b_r};
    inc  = {sa, a_a_r} + 33'd1;
    dec  = {sa, a_a_r} - 33'd1;
    wide = {a_a_r, {FRAC_BITS{1'b0}}};

    b_nxt      = '0;
    b_nxt.v    = a_v_r;
    b_nxt.cmd  = a_cmd_r;
    b_nxt.lt   = $signed(a_a_r) < $signed(a_b_r);
    b_nxt.eq   = a_a_r == a_b_r;
    b_nxt.gt   = $signed(a_a_r) > $signed(a_b_r);
    b_nxt.neg  = sa ^ sb;
    b_nxt.maga = sa ? 32'(0 - a_a_r) : a_a_r;
    b_nxt.den  = magb;
    b_nxt.num  = {b_nxt.maga, {FRAC_BITS{1'b0}}};
    b_nxt.st   = ST_OK;
    ft         = b_nxt.maga >> FRAC_BITS;

    case (a_cmd_r)
      CMD_ADD: b_nxt.simple = sat33(sum, b_nxt.st);
      CMD_SUB: b_nxt.simple = sat33(dif, b_nxt.st);
      CMD_INC: b_nxt.simple = sat33(inc, b_nxt.st);
      CMD_DEC: b_nxt.simple = sat33(dec, b_nxt.st);
      CMD_MIN: b_nxt.simple = b_nxt.gt ? a_b_r : a_a_r;
      CMD_MAX: b_nxt.simple = b_nxt.lt ? a_b_r : a_a_r;
      CMD_ITOF: begin
        // fits only when bit 31 and all the bits above it copy the sign
        if (wide[31+FRAC_BITS:31] != {(FRAC_BITS+1){sa}}) begin
          b_nxt.simple = sa ? S32_MIN : S32_MAX;
          b_nxt.st     = ST_OVF;
        end else begin
          b_nxt.simple = wide[31:0];
        end
      end
      CMD_FTOI: b_nxt.simple = sa ? 32'(0 - ft) : ft;
      CMD_DIV: begin
        if (magb == '0) begin
          b_nxt.dz     = 1'b1;
          b_nxt.st     = ST_DZ;
          b_nxt.simple = sa ? S32_MIN : ((a_a_r == '0) ? '0 : S32_MAX);
        end
      end
      default: b_nxt.simple = '0;
    endcase
  end

  // magnitude product
  always_comb begin
    c_nxt      = b_r;
    c_nxt.prod = 64'(b_r.maga) * 64'(b_r.den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.v <= 1'b0;
      c_r.v <= 1'b0;
    end else if (en) begin
      b_r <= b_nxt;
      c_r <= c_nxt;
    end
  end

  fpa_div_pipe u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_s  (c_r),
    .out_s (d_out)
  );

  // round to nearest, halves away from zero, on magnitudes
  always_comb begin
    logic rbit;
    rbit   = {d_out.rem, 1'b0} >= {1'b0, d_out.den};
    f1_nxt = d_out;
    if (d_out.cmd == CMD_MUL) begin
      f1_nxt.rnd = (d_out.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    end else begin
      f1_nxt.rnd = 64'(d_out.quo) + 64'(rbit);
    end
  end

  // restore sign and saturate
  always_comb begin
    f2_nxt = f1_r;
    if (f1_r.cmd == CMD_MUL || (f1_r.cmd == CMD_DIV && !f1_r.dz)) begin
      f2_nxt.st = ST_OK;
      if (f1_r.neg) begin
        if (f1_r.rnd > 64'h8000_0000) begin
          f2_nxt.simple = S32_MIN;
          f2_nxt.st     = ST_OVF;
        end else begin
          f2_nxt.simple = 32'(64'd0 - f1_r.rnd);
        end
      end else if (f1_r.rnd > 64'h7fff_ffff) begin
        f2_nxt.simple = S32_MAX;
        f2_nxt.st     = ST_OVF;
      end else begin
        f2_nxt.simple = f1_r.rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r.v <= 1'b0;
      f2_r.v <= 1'b0;
    end else if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  assign f2_word = '{result: f2_r.simple, lt: f2_r.lt, eq: f2_r.eq, gt: f2_r.gt, st: f2_r.st};

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (en) begin
      if (!out_v_r || out_ch.ready) begin
        out_v_r <= f2_r.v;
        out_r   <= f2_word;
      end else if (f2_r.v) begin
        skid_v_r <= 1'b1;
        skid_r   <= f2_word;
      end
    end else if (out_ch.ready) begin
      out_r    <= skid_r;
      skid_v_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.result    = out_r.result;
  assign out_ch.a_less    = out_r.lt;
  assign out_ch.a_equal   = out_r.eq;
  assign out_ch.a_greater = out_r.gt;
  assign out_ch.status    = out_r.st;

endmodule

// File: sv/fpa_div_pipe.sv
module fpa_div_pipe (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  fpa_pkg::stage_t in_s,
  output fpa_pkg::stage_t out_s
);
  import fpa_pkg::*;

  // restoring divider, one quotient bit per stage, MSB first
  stage_t stg_r [NUM_W];
  stage_t stg_nxt [NUM_W];

  always_comb begin
    for (int k = 0; k < NUM_W; k++) begin
      stage_t     p;
      logic [32:0] t;
      p = (k == 0) ? in_s : stg_r[(k == 0) ? 0 : k - 1];
      t = {p.rem, p.num[NUM_W-1]};
      stg_nxt[k] = p;
      stg_nxt[k].num = {p.num[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, p.den}) begin
        stg_nxt[k].rem = 32'(t - {1'b0, p.den});
        stg_nxt[k].quo = {p.quo[NUM_W-2:0], 1'b1};
      end else begin
        stg_nxt[k].rem = t[31:0];
        stg_nxt[k].quo = {p.quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_W; k++) begin
      if (!rst_n) begin
        stg_r[k].v <= 1'b0;
      end else if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_s = stg_r[NUM_W-1];

endmodule

// File: sv/fpa_checker.sv
module fpa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic        out_a_less,
  input logic        out_a_equal,
  input logic        out_a_greater,
  input logic [1:0]  out_status
);
  import fpa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("stalled output word changed");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("compare flags not exclusive");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DZ |->
      out_result == S32_MAX || out_result == S32_MIN || out_result == 32'd0)
    else $error("divide by zero result not saturated");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_result    (out_ch.result),
  .out_a_less    (out_ch.a_less),
  .out_a_equal   (out_ch.a_equal),
  .out_a_greater (out_ch.a_greater),
  .out_status    (out_ch.status)
);
